### src/sgew_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgew_pkg
// Types, register addresses and gain tables shared by the sensor gain and
// exposure writer and its checker.
// ----------------------------------------------------------------------------
package sgew_pkg;

    localparam int GAIN_W     = 20;
    localparam int EXP_W      = 13;
    localparam int BYTE_W     = 8;
    localparam int Q6_W       = 17;   // (2^20 - 1 + 8) >> 4 = 65536
    localparam int NUM_W      = 23;   // 64 * 65536 = 2^22
    localparam int RECIP_W    = 27;   // 2^32 / 64 = 2^26
    localparam int PROD_W     = NUM_W + RECIP_W;
    localparam int RECIP_SH   = 32;
    localparam int DGAIN_W    = 13;   // largest digital gain is 4928
    localparam int STEP_W     = 4;
    localparam int NUM_STEPS  = 9;
    localparam int GAP_W      = 3;
    localparam int WRITES_PER_ITEM = 7;

    localparam logic [Q6_W-1:0] GAIN_UNIT_Q6 = 17'd64;

    localparam logic [Q6_W-1:0] STEP_THRESHOLD [NUM_STEPS] = '{
        17'd64, 17'd90, 17'd118, 17'd163, 17'd218,
        17'd304, 17'd438, 17'd602, 17'd851
    };

    localparam longint unsigned TWO_POW_SH = 64'd1 << RECIP_SH;

    // Rounded-up reciprocals; with a 23-bit numerator the truncated product
    // gives the exact floor quotient for every threshold.
    localparam logic [RECIP_W-1:0] STEP_RECIP [NUM_STEPS] = '{
        RECIP_W'((TWO_POW_SH + 64'd64  - 64'd1) / 64'd64),
        RECIP_W'((TWO_POW_SH + 64'd90  - 64'd1) / 64'd90),
        RECIP_W'((TWO_POW_SH + 64'd118 - 64'd1) / 64'd118),
        RECIP_W'((TWO_POW_SH + 64'd163 - 64'd1) / 64'd163),
        RECIP_W'((TWO_POW_SH + 64'd218 - 64'd1) / 64'd218),
        RECIP_W'((TWO_POW_SH + 64'd304 - 64'd1) / 64'd304),
        RECIP_W'((TWO_POW_SH + 64'd438 - 64'd1) / 64'd438),
        RECIP_W'((TWO_POW_SH + 64'd602 - 64'd1) / 64'd602),
        RECIP_W'((TWO_POW_SH + 64'd851 - 64'd1) / 64'd851)
    };

    localparam logic [BYTE_W-1:0] ADDR_PAGE     = 8'hfe;
    localparam logic [BYTE_W-1:0] ADDR_AGAIN    = 8'hb6;
    localparam logic [BYTE_W-1:0] ADDR_DGAIN_HI = 8'hb1;
    localparam logic [BYTE_W-1:0] ADDR_DGAIN_LO = 8'hb2;
    localparam logic [BYTE_W-1:0] ADDR_EXP_LO   = 8'h04;
    localparam logic [BYTE_W-1:0] ADDR_EXP_HI   = 8'h03;

    localparam logic [BYTE_W-1:0] PAGE_ONE  = 8'h01;
    localparam logic [BYTE_W-1:0] PAGE_ZERO = 8'h00;

    typedef enum logic [2:0] {
        BEAT_PAGE1    = 3'd0,
        BEAT_AGAIN    = 3'd1,
        BEAT_DGAIN_HI = 3'd2,
        BEAT_DGAIN_LO = 3'd3,
        BEAT_PAGE0    = 3'd4,
        BEAT_EXP_LO   = 3'd5,
        BEAT_EXP_HI   = 3'd6
    } beat_t;

endpackage

### src/sensor_gain_exposure_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_gain_exposure_writer
// Turns a Q10 gain and an exposure in lines into seven sensor register writes.
// ----------------------------------------------------------------------------
// Order: an accepted item passes stages 1 to 3, the write sequencer and the
// output register to reach the ports; its seven writes then follow on
// consecutive cycles. Busy holds off starts while the gap counter counts down;
// the next item can then be taken while the last one's writes still go out.
// Reset clears all valid bits, the sequencer and the output strobe. The
// receiver cannot stall, so a run of writes is never interrupted.
module sensor_gain_exposure_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sgew_pkg::GAIN_W-1:0]   gain_q10,
    input  logic [sgew_pkg::EXP_W-1:0]    exposure_lines,
    output logic                          write_strobe,
    output logic [sgew_pkg::BYTE_W-1:0]   reg_addr,
    output logic [sgew_pkg::BYTE_W-1:0]   reg_value,
    output logic                          last_write
);
    import sgew_pkg::*;

    logic                   accept;
    logic [GAP_W-1:0]       gap_reg, gap_next;

    // Stage 1: rounded and clamped gain.
    logic                   s1_valid_reg;
    logic [Q6_W-1:0]        s1_q6_reg, s1_q6_next;
    logic [EXP_W-1:0]       s1_exp_reg;
    logic [GAIN_W:0]        round_sum;

    // Stage 2: analog step, numerator and reciprocal.
    logic                   s2_valid_reg;
    logic [STEP_W-1:0]      s2_step_reg, s2_step_next;
    logic [NUM_W-1:0]       s2_num_reg;
    logic [RECIP_W-1:0]     s2_recip_reg;
    logic [EXP_W-1:0]       s2_exp_reg;

    // Stage 3: product.
    logic                   s3_valid_reg;
    logic [PROD_W-1:0]      s3_prod_reg;
    logic [STEP_W-1:0]      s3_step_reg;
    logic [EXP_W-1:0]       s3_exp_reg;

    // Write sequencer.
    logic                   seq_active_reg, seq_active_next;
    beat_t                  beat_reg, beat_next;
    logic [DGAIN_W-1:0]     seq_dgain_reg;
    logic [STEP_W-1:0]      seq_step_reg;
    logic [EXP_W-1:0]       seq_exp_reg;

    // Output register.
    logic                   strobe_reg;
    logic                   last_reg, last_next;
    logic [BYTE_W-1:0]      addr_reg, addr_next;
    logic [BYTE_W-1:0]      value_reg, value_next;

    assign busy   = (gap_reg != '0);
    assign accept = start && !busy;

    always_comb
    begin
        if (accept)
        begin
            gap_next = GAP_W'(WRITES_PER_ITEM - 1);
        end
        else if (gap_reg != '0)
        begin
            gap_next = gap_reg - 1'b1;
        end
        else
        begin
            gap_next = gap_reg;
        end
    end

    always_comb
    begin
        round_sum = {1'b0, gain_q10} + (GAIN_W + 1)'(8);
        s1_q6_next = round_sum[GAIN_W:4];
        if (s1_q6_next < GAIN_UNIT_Q6)
        begin
            s1_q6_next = GAIN_UNIT_Q6;
        end
    end

    // Thresholds rise, so the last one passed is the highest.
    always_comb
    begin
        s2_step_next = '0;
        for (int i = 1; i < NUM_STEPS; i++)
        begin
            if (s1_q6_reg >= STEP_THRESHOLD[i])
            begin
                s2_step_next = STEP_W'(i);
            end
        end
    end

    // A new item reaches the sequencer on the same edge its last beat leaves.
    always_comb
    begin
        seq_active_next = seq_active_reg;
        beat_next       = beat_reg;
        if (s3_valid_reg)
        begin
            seq_active_next = 1'b1;
            beat_next       = BEAT_PAGE1;
        end
        else if (seq_active_reg)
        begin
            if (beat_reg == BEAT_EXP_HI)
            begin
                seq_active_next = 1'b0;
            end
            else
            begin
                beat_next = beat_t'(beat_reg + 3'd1);
            end
        end
    end

    always_comb
    begin
        addr_next  = ADDR_PAGE;
        value_next = PAGE_ONE;
        last_next  = 1'b0;
        unique case (beat_reg)
            BEAT_PAGE1:
            begin
                addr_next  = ADDR_PAGE;
                value_next = PAGE_ONE;
            end
            BEAT_AGAIN:
            begin
                addr_next  = ADDR_AGAIN;
                value_next = BYTE_W'(seq_step_reg);
            end
            BEAT_DGAIN_HI:
            begin
                addr_next  = ADDR_DGAIN_HI;
                value_next = BYTE_W'(seq_dgain_reg >> 6);
            end
            BEAT_DGAIN_LO:
            begin
                addr_next  = ADDR_DGAIN_LO;
                value_next = {seq_dgain_reg[5:0], 2'b00};
            end
            BEAT_PAGE0:
            begin
                addr_next  = ADDR_PAGE;
                value_next = PAGE_ZERO;
            end
            BEAT_EXP_LO:
            begin
                addr_next  = ADDR_EXP_LO;
                value_next = seq_exp_reg[7:0];
            end
            BEAT_EXP_HI:
            begin
                addr_next  = ADDR_EXP_HI;
                value_next = {3'b000, seq_exp_reg[12:8]};
                last_next  = seq_active_reg;
            end
            default:
            begin
                addr_next  = ADDR_PAGE;
                value_next = PAGE_ONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            seq_active_reg <= 1'b0;
            beat_reg       <= BEAT_PAGE1;
            strobe_reg     <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            gap_reg        <= gap_next;
            s1_valid_reg   <= accept;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            seq_active_reg <= seq_active_next;
            beat_reg       <= beat_next;
            strobe_reg     <= seq_active_reg;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_q6_reg  <= s1_q6_next;
            s1_exp_reg <= exposure_lines;
        end
        if (s1_valid_reg)
        begin
            s2_step_reg  <= s2_step_next;
            s2_num_reg   <= {s1_q6_reg, 6'b000000};
            s2_recip_reg <= STEP_RECIP[s2_step_next];
            s2_exp_reg   <= s1_exp_reg;
        end
        if (s2_valid_reg)
        begin
            s3_prod_reg <= PROD_W'(s2_num_reg) * PROD_W'(s2_recip_reg);
            s3_step_reg <= s2_step_reg;
            s3_exp_reg  <= s2_exp_reg;
        end
        if (s3_valid_reg)
        begin
            seq_dgain_reg <= s3_prod_reg[RECIP_SH +: DGAIN_W];
            seq_step_reg  <= s3_step_reg;
            seq_exp_reg   <= s3_exp_reg;
        end
        addr_reg  <= addr_next;
        value_reg <= value_next;
    end

    assign write_strobe = strobe_reg;
    assign reg_addr     = addr_reg;
    assign reg_value    = value_reg;
    assign last_write   = last_reg;

endmodule

### src/sgew_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgew_checker
// Port-level checks on the write sequence of the sensor gain exposure writer.
// ----------------------------------------------------------------------------
module sgew_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          write_strobe,
    input  logic [sgew_pkg::BYTE_W-1:0]   reg_addr,
    input  logic [sgew_pkg::BYTE_W-1:0]   reg_value,
    input  logic                          last_write
);
    import sgew_pkg::*;

    // An accepted start blocks the next one.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted start");

    a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_write |-> write_strobe && reg_addr == ADDR_EXP_HI)
        else $error("final beat flag without the exposure high write");

    // A run of writes always opens with the page 1 select.
    a_run_opens_page1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(write_strobe) |-> reg_addr == ADDR_PAGE && reg_value == PAGE_ONE)
        else $error("write run did not open with page 1 select");

    // The seven beats of a run are contiguous.
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        write_strobe && !last_write |=> write_strobe)
        else $error("write run broken before its final beat");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        write_strobe && reg_addr == ADDR_AGAIN |-> reg_value < 8'd9)
        else $error("analog step out of range");

endmodule

bind sensor_gain_exposure_writer sgew_checker u_sgew_checker (.*);
